// File: hw/rtl/cpu8_register_alu_execute_macros.svh
// Assertion macros shared by the execute block.
`ifndef CPU8_REGISTER_ALU_EXECUTE_MACROS_SVH
`define CPU8_REGISTER_ALU_EXECUTE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPU8_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPU8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/cpu8_pkg.sv
`timescale 1ns / 1ps

package cpu8_pkg;

    localparam int unsigned KIND_W = 6;

    localparam logic [KIND_W-1:0] KIND_ADC = 6'd0;
    localparam logic [KIND_W-1:0] KIND_SBC = 6'd1;
    localparam logic [KIND_W-1:0] KIND_AND = 6'd2;
    localparam logic [KIND_W-1:0] KIND_ORA = 6'd3;
    localparam logic [KIND_W-1:0] KIND_EOR = 6'd4;
    localparam logic [KIND_W-1:0] KIND_ASL = 6'd5;
    localparam logic [KIND_W-1:0] KIND_LSR = 6'd6;
    localparam logic [KIND_W-1:0] KIND_ROL = 6'd7;
    localparam logic [KIND_W-1:0] KIND_ROR = 6'd8;
    localparam logic [KIND_W-1:0] KIND_BIT = 6'd9;
    localparam logic [KIND_W-1:0] KIND_CMP = 6'd10;
    localparam logic [KIND_W-1:0] KIND_CPX = 6'd11;
    localparam logic [KIND_W-1:0] KIND_CPY = 6'd12;
    localparam logic [KIND_W-1:0] KIND_BCC = 6'd13;
    localparam logic [KIND_W-1:0] KIND_BCS = 6'd14;
    localparam logic [KIND_W-1:0] KIND_BEQ = 6'd15;
    localparam logic [KIND_W-1:0] KIND_BNE = 6'd16;
    localparam logic [KIND_W-1:0] KIND_BVC = 6'd17;
    localparam logic [KIND_W-1:0] KIND_BVS = 6'd18;
    localparam logic [KIND_W-1:0] KIND_BPL = 6'd19;
    localparam logic [KIND_W-1:0] KIND_BMI = 6'd20;
    localparam logic [KIND_W-1:0] KIND_INC = 6'd21;
    localparam logic [KIND_W-1:0] KIND_DEC = 6'd22;
    localparam logic [KIND_W-1:0] KIND_INX = 6'd23;
    localparam logic [KIND_W-1:0] KIND_DEX = 6'd24;
    localparam logic [KIND_W-1:0] KIND_INY = 6'd25;
    localparam logic [KIND_W-1:0] KIND_DEY = 6'd26;
    localparam logic [KIND_W-1:0] KIND_CLC = 6'd27;
    localparam logic [KIND_W-1:0] KIND_SEC = 6'd28;
    localparam logic [KIND_W-1:0] KIND_CLI = 6'd29;
    localparam logic [KIND_W-1:0] KIND_SEI = 6'd30;
    localparam logic [KIND_W-1:0] KIND_CLD = 6'd31;
    localparam logic [KIND_W-1:0] KIND_SED = 6'd32;
    localparam logic [KIND_W-1:0] KIND_CLV = 6'd33;
    localparam logic [KIND_W-1:0] KIND_LDA = 6'd34;
    localparam logic [KIND_W-1:0] KIND_LDX = 6'd35;
    localparam logic [KIND_W-1:0] KIND_LDY = 6'd36;
    localparam logic [KIND_W-1:0] KIND_STA = 6'd37;
    localparam logic [KIND_W-1:0] KIND_STX = 6'd38;
    localparam logic [KIND_W-1:0] KIND_STY = 6'd39;
    localparam logic [KIND_W-1:0] KIND_TAX = 6'd40;
    localparam logic [KIND_W-1:0] KIND_TXA = 6'd41;
    localparam logic [KIND_W-1:0] KIND_TAY = 6'd42;
    localparam logic [KIND_W-1:0] KIND_TYA = 6'd43;
    localparam logic [KIND_W-1:0] KIND_TSX = 6'd44;
    localparam logic [KIND_W-1:0] KIND_TXS = 6'd45;
    localparam logic [KIND_W-1:0] KIND_PHA = 6'd46;
    localparam logic [KIND_W-1:0] KIND_PLA = 6'd47;
    localparam logic [KIND_W-1:0] KIND_PHP = 6'd48;
    localparam logic [KIND_W-1:0] KIND_PLP = 6'd49;

    // Bit positions in the status byte.
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_B = 4;
    localparam int unsigned FLAG_U = 5;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    localparam logic [7:0] SP_RESET     = 8'hFD;
    localparam logic [7:0] STATUS_RESET = 8'h24;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] status;
    } cpu_state_t;

    typedef struct packed {
        logic       mem_write;
        logic [7:0] write_data;
        logic [7:0] stack_slot;
        logic       branch_taken;
    } side_result_t;

endpackage

// File: hw/rtl/cpu8_register_alu_execute.sv
// A beat is registered in the input stage, then moves to the output registers when the output stage is ready.
// Throughput: one beat per cycle while out_stall is low; the ALU between the stages is combinational.
// The input stage takes a new beat whenever it is empty or its beat moves to the output stage.
// Reset: A, X and Y clear to zero, SP to 0xFD, status to 0x24, and both stages empty.
`timescale 1ns / 1ps

module cpu8_register_alu_execute (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [cpu8_pkg::KIND_W-1:0] kind,
    input  logic [7:0]                  operand,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  acc_out,
    output logic [7:0]                  x_out,
    output logic [7:0]                  y_out,
    output logic [7:0]                  sp_out,
    output logic [7:0]                  status_out,
    output logic                        mem_write,
    output logic [7:0]                  write_data,
    output logic [7:0]                  stack_slot,
    output logic                        branch_taken
);
    import cpu8_pkg::*;
    `include "cpu8_register_alu_execute_macros.svh"

    logic                 s1_valid_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [7:0]           operand_reg;
    cpu_state_t           state_reg;
    cpu_state_t           state_next;
    side_result_t         side_next;
    logic                 out_valid_reg;
    cpu_state_t           out_state_reg;
    side_result_t         out_side_reg;
    logic                 out_ready;
    logic                 s1_advance;

    assign out_ready  = ~out_valid_reg | ~out_stall;
    assign s1_advance = s1_valid_reg & out_ready;
    assign in_stall   = s1_valid_reg & ~out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            kind_reg    <= kind;
            operand_reg <= operand;
        end
    end

    cpu8_alu u_alu (
        .kind       (kind_reg),
        .operand    (operand_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .side       (side_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.acc    <= 8'h00;
            state_reg.x      <= 8'h00;
            state_reg.y      <= 8'h00;
            state_reg.sp     <= SP_RESET;
            state_reg.status <= STATUS_RESET;
        end
        else if (s1_advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_state_reg <= state_next;
            out_side_reg  <= side_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign acc_out      = out_state_reg.acc;
    assign x_out        = out_state_reg.x;
    assign y_out        = out_state_reg.y;
    assign sp_out       = out_state_reg.sp;
    assign status_out   = out_state_reg.status;
    assign mem_write    = out_side_reg.mem_write;
    assign write_data   = out_side_reg.write_data;
    assign stack_slot   = out_side_reg.stack_slot;
    assign branch_taken = out_side_reg.branch_taken;

    // The held result always reflects the current architectural registers.
    `CPU8_ASSERT_SAME(a_out_matches_state, clk, rst_n, out_valid_reg,
        out_state_reg == state_reg, "output registers differ from architectural state")

    `CPU8_ASSERT_SAME(a_no_write_data, clk, rst_n, out_valid_reg && !out_side_reg.mem_write,
        out_side_reg.write_data == 8'h00, "write data nonzero without a memory write")

    `CPU8_ASSERT_SAME(a_branch_no_side, clk, rst_n, out_valid_reg && out_side_reg.branch_taken,
        !out_side_reg.mem_write && out_side_reg.stack_slot == 8'h00,
        "taken branch also reports a write or stack access")

    `CPU8_ASSERT_NEXT(a_drain, clk, rst_n, out_valid_reg && !out_stall && !s1_valid_reg,
        !out_valid_reg, "output beat repeated after it was taken")

    `CPU8_ASSERT_SAME(a_free_output_no_stall, clk, rst_n, !out_valid_reg,
        !in_stall, "input stalled while the output stage is empty")

endmodule

// File: hw/rtl/cpu8_alu.sv
`timescale 1ns / 1ps

module cpu8_alu (
    input  logic [cpu8_pkg::KIND_W-1:0] kind,
    input  logic [7:0]                  operand,
    input  cpu8_pkg::cpu_state_t        state_cur,
    output cpu8_pkg::cpu_state_t        state_next,
    output cpu8_pkg::side_result_t      side
);
    import cpu8_pkg::*;

    function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        r         = p;
        r[FLAG_N] = v[7];
        r[FLAG_Z] = (v == 8'h00);
        return r;
    endfunction

    logic [7:0] addend;
    logic [8:0] sum;
    logic [7:0] sum_lo;
    logic       sum_v;
    logic [7:0] cmp_reg;
    logic [8:0] cmp_diff;
    logic [7:0] p;

    assign p       = state_cur.status;
    assign addend  = (kind == KIND_SBC) ? ~operand : operand;
    assign sum     = {1'b0, state_cur.acc} + {1'b0, addend} + {8'h00, p[FLAG_C]};
    assign sum_lo  = sum[7:0];
    assign sum_v   = ~(state_cur.acc[7] ^ addend[7]) & (state_cur.acc[7] ^ sum_lo[7]);

    always_comb
    begin
        case (kind)
            KIND_CPX: cmp_reg = state_cur.x;
            KIND_CPY: cmp_reg = state_cur.y;
            default:  cmp_reg = state_cur.acc;
        endcase
    end

    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

    always_comb
    begin
        state_next        = state_cur;
        side.mem_write    = 1'b0;
        side.write_data   = 8'h00;
        side.stack_slot   = 8'h00;
        side.branch_taken = 1'b0;
        case (kind)
            KIND_ADC, KIND_SBC:
            begin
                state_next.acc              = sum_lo;
                state_next.status           = with_nz(p, sum_lo);
                state_next.status[FLAG_C]   = sum[8];
                state_next.status[FLAG_V]   = sum_v;
            end
            KIND_AND:
            begin
                state_next.acc    = state_cur.acc & operand;
                state_next.status = with_nz(p, state_cur.acc & operand);
            end
            KIND_ORA:
            begin
                state_next.acc    = state_cur.acc | operand;
                state_next.status = with_nz(p, state_cur.acc | operand);
            end
            KIND_EOR:
            begin
                state_next.acc    = state_cur.acc ^ operand;
                state_next.status = with_nz(p, state_cur.acc ^ operand);
            end
            KIND_ASL:
            begin
                state_next.acc            = {state_cur.acc[6:0], 1'b0};
                state_next.status         = with_nz(p, {state_cur.acc[6:0], 1'b0});
                state_next.status[FLAG_C] = state_cur.acc[7];
            end
            KIND_LSR:
            begin
                state_next.acc            = {1'b0, state_cur.acc[7:1]};
                state_next.status         = with_nz(p, {1'b0, state_cur.acc[7:1]});
                state_next.status[FLAG_C] = state_cur.acc[0];
            end
            KIND_ROL:
            begin
                state_next.acc            = {state_cur.acc[6:0], p[FLAG_C]};
                state_next.status         = with_nz(p, {state_cur.acc[6:0], p[FLAG_C]});
                state_next.status[FLAG_C] = state_cur.acc[7];
            end
            KIND_ROR:
            begin
                state_next.acc            = {p[FLAG_C], state_cur.acc[7:1]};
                state_next.status         = with_nz(p, {p[FLAG_C], state_cur.acc[7:1]});
                state_next.status[FLAG_C] = state_cur.acc[0];
            end
            KIND_BIT:
            begin
                state_next.status[FLAG_N] = operand[7];
                state_next.status[FLAG_V] = operand[6];
                state_next.status[FLAG_Z] = ((state_cur.acc & operand) == 8'h00);
            end
            KIND_CMP, KIND_CPX, KIND_CPY:
            begin
                state_next.status         = with_nz(p, cmp_diff[7:0]);
                state_next.status[FLAG_C] = ~cmp_diff[8];
            end
            KIND_BCC: side.branch_taken = ~p[FLAG_C];
            KIND_BCS: side.branch_taken = p[FLAG_C];
            KIND_BEQ: side.branch_taken = p[FLAG_Z];
            KIND_BNE: side.branch_taken = ~p[FLAG_Z];
            KIND_BVC: side.branch_taken = ~p[FLAG_V];
            KIND_BVS: side.branch_taken = p[FLAG_V];
            KIND_BPL: side.branch_taken = ~p[FLAG_N];
            KIND_BMI: side.branch_taken = p[FLAG_N];
            KIND_INC:
            begin
                side.mem_write    = 1'b1;
                side.write_data   = operand + 8'd1;
                state_next.status = with_nz(p, operand + 8'd1);
            end
            KIND_DEC:
            begin
                side.mem_write    = 1'b1;
                side.write_data   = operand - 8'd1;
                state_next.status = with_nz(p, operand - 8'd1);
            end
            KIND_INX:
            begin
                state_next.x      = state_cur.x + 8'd1;
                state_next.status = with_nz(p, state_cur.x + 8'd1);
            end
            KIND_DEX:
            begin
                state_next.x      = state_cur.x - 8'd1;
                state_next.status = with_nz(p, state_cur.x - 8'd1);
            end
            KIND_INY:
            begin
                state_next.y      = state_cur.y + 8'd1;
                state_next.status = with_nz(p, state_cur.y + 8'd1);
            end
            KIND_DEY:
            begin
                state_next.y      = state_cur.y - 8'd1;
                state_next.status = with_nz(p, state_cur.y - 8'd1);
            end
            KIND_CLC: state_next.status[FLAG_C] = 1'b0;
            KIND_SEC: state_next.status[FLAG_C] = 1'b1;
            KIND_CLI: state_next.status[FLAG_I] = 1'b0;
            KIND_SEI: state_next.status[FLAG_I] = 1'b1;
            KIND_CLD: state_next.status[FLAG_D] = 1'b0;
            KIND_SED: state_next.status[FLAG_D] = 1'b1;
            KIND_CLV: state_next.status[FLAG_V] = 1'b0;
            KIND_LDA:
            begin
                state_next.acc    = operand;
                state_next.status = with_nz(p, operand);
            end
            KIND_LDX:
            begin
                state_next.x      = operand;
                state_next.status = with_nz(p, operand);
            end
            KIND_LDY:
            begin
                state_next.y      = operand;
                state_next.status = with_nz(p, operand);
            end
            KIND_STA:
            begin
                side.mem_write  = 1'b1;
                side.write_data = state_cur.acc;
            end
            KIND_STX:
            begin
                side.mem_write  = 1'b1;
                side.write_data = state_cur.x;
            end
            KIND_STY:
            begin
                side.mem_write  = 1'b1;
                side.write_data = state_cur.y;
            end
            KIND_TAX:
            begin
                state_next.x      = state_cur.acc;
                state_next.status = with_nz(p, state_cur.acc);
            end
            KIND_TXA:
            begin
                state_next.acc    = state_cur.x;
                state_next.status = with_nz(p, state_cur.x);
            end
            KIND_TAY:
            begin
                state_next.y      = state_cur.acc;
                state_next.status = with_nz(p, state_cur.acc);
            end
            KIND_TYA:
            begin
                state_next.acc    = state_cur.y;
                state_next.status = with_nz(p, state_cur.y);
            end
            KIND_TSX:
            begin
                state_next.x      = state_cur.sp;
                state_next.status = with_nz(p, state_cur.sp);
            end
            KIND_TXS: state_next.sp = state_cur.x;
            KIND_PHA:
            begin
                side.mem_write  = 1'b1;
                side.write_data = state_cur.acc;
                side.stack_slot = state_cur.sp;
                state_next.sp   = state_cur.sp - 8'd1;
            end
            KIND_PLA:
            begin
                state_next.sp     = state_cur.sp + 8'd1;
                side.stack_slot   = state_cur.sp + 8'd1;
                state_next.acc    = operand;
                state_next.status = with_nz(p, operand);
            end
            KIND_PHP:
            begin
                side.mem_write            = 1'b1;
                side.write_data           = p;
                side.write_data[FLAG_B]   = 1'b1;
                side.write_data[FLAG_U]   = 1'b1;
                side.stack_slot           = state_cur.sp;
                state_next.sp             = state_cur.sp - 8'd1;
            end
            KIND_PLP:
            begin
                state_next.sp             = state_cur.sp + 8'd1;
                side.stack_slot           = state_cur.sp + 8'd1;
                state_next.status         = operand;
                state_next.status[FLAG_B] = 1'b0;
                state_next.status[FLAG_U] = 1'b1;
            end
            default:
            begin
                state_next = state_cur;
            end
        endcase
    end

endmodule
